>>> rtl/lrct_pkg.sv
`default_nettype none

package lrct_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int SCAN_W        = $clog2(TABLE_ENTRIES + 1);
    localparam int KEY_W         = 64;
    localparam int COUNT_W       = 64;
    localparam int SLOT_W        = KEY_W + COUNT_W;

    localparam logic REQ_INC = 1'b0;
    localparam logic REQ_DEC = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } ctrl_state_t;

    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/lrct_ram.sv
`default_nettype none

module lrct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/lrct_ctrl.sv
`default_nettype none

module lrct_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output lrct_pkg::dp_cmd_t        cmd,
    input  wire lrct_pkg::dp_status_t status
);

    import lrct_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd.start  = 1'b0;
        cmd.scan   = 1'b0;
        cmd.commit = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.start = in_valid;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_UPDATE:
            begin
                cmd.commit = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    a_start_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> state_reg == ST_SCAN)
        else $error("accepted word did not start a scan");

    a_scan_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && !status.scan_done) |=> state_reg == ST_SCAN)
        else $error("scan left early");

    a_update_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE && !status.out_free) |=> state_reg == ST_UPDATE)
        else $error("update left while output busy");

endmodule

`default_nettype wire

>>> rtl/lrct_dp.sv
`default_nettype none

module lrct_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire lrct_pkg::dp_cmd_t             cmd,
    output lrct_pkg::dp_status_t               status,
    input  wire logic                          req_type,
    input  wire logic [lrct_pkg::KEY_W-1:0]    entry_key,
    input  wire logic [lrct_pkg::COUNT_W-1:0]  dec_amount,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               first_insert,
    output logic                               last_remove,
    output logic                               key_absent,
    output logic                               table_full
);

    import lrct_pkg::*;

    // latched request
    logic               req_type_reg;
    logic [KEY_W-1:0]   req_key_reg;
    logic [COUNT_W-1:0] req_amount_reg;

    // scan state
    logic [SCAN_W-1:0]        scan_cnt_reg;
    logic [SCAN_W-1:0]        scan_cnt_next;
    logic                     cmp_vld_reg;
    logic [IDX_W-1:0]         cmp_idx_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [TABLE_ENTRIES-1:0] valid_next;

    logic               found_reg;
    logic               found_next;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [IDX_W-1:0]   hit_idx_next;
    logic [COUNT_W-1:0] hit_count_reg;
    logic [COUNT_W-1:0] hit_count_next;
    logic               free_found_reg;
    logic               free_found_next;
    logic [IDX_W-1:0]   free_idx_reg;
    logic [IDX_W-1:0]   free_idx_next;

    // result
    logic out_valid_reg;
    logic out_valid_next;
    logic first_insert_reg;
    logic last_remove_reg;
    logic key_absent_reg;
    logic table_full_reg;
    logic first_insert_next;
    logic last_remove_next;
    logic key_absent_next;
    logic table_full_next;

    // memory
    logic              rd_en;
    logic [SLOT_W-1:0] rd_data;
    logic [KEY_W-1:0]  rd_key;
    logic [COUNT_W-1:0] rd_count;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [COUNT_W-1:0] new_count;

    logic               cmp_slot_valid;
    logic [COUNT_W-1:0] inc_count;
    logic [COUNT_W-1:0] sub_count;
    logic               dec_frees;
    logic               is_inc;

    assign rd_en    = cmd.scan && (scan_cnt_reg != SCAN_W'(TABLE_ENTRIES));
    assign rd_key   = rd_data[SLOT_W-1:COUNT_W];
    assign rd_count = rd_data[COUNT_W-1:0];

    lrct_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({req_key_reg, new_count}),
        .re    (rd_en),
        .raddr (scan_cnt_reg[IDX_W-1:0]),
        .rdata (rd_data)
    );

    assign cmp_slot_valid = valid_reg[cmp_idx_reg];

    // scan bookkeeping
    always_comb
    begin
        scan_cnt_next   = scan_cnt_reg;
        found_next      = found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_count_next  = hit_count_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        if (cmd.start)
        begin
            scan_cnt_next   = '0;
            found_next      = 1'b0;
            free_found_next = 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                scan_cnt_next = scan_cnt_reg + SCAN_W'(1);
            end
            if (cmp_vld_reg)
            begin
                if (cmp_slot_valid && rd_key == req_key_reg && !found_reg)
                begin
                    found_next     = 1'b1;
                    hit_idx_next   = cmp_idx_reg;
                    hit_count_next = rd_count;
                end
                if (!cmp_slot_valid && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = cmp_idx_reg;
                end
            end
        end
    end

    assign status.scan_done = cmp_vld_reg && (cmp_idx_reg == IDX_W'(TABLE_ENTRIES - 1));
    assign status.out_free  = !out_valid_reg || out_ready;

    // update
    assign is_inc    = (req_type_reg == REQ_INC);
    assign inc_count = (hit_count_reg == '1) ? hit_count_reg : hit_count_reg + COUNT_W'(1);
    assign sub_count = hit_count_reg - req_amount_reg;
    assign dec_frees = (req_amount_reg >= hit_count_reg);

    always_comb
    begin
        ram_we            = 1'b0;
        ram_waddr         = found_reg ? hit_idx_reg : free_idx_reg;
        new_count         = COUNT_W'(1);
        valid_next        = valid_reg;
        first_insert_next = first_insert_reg;
        last_remove_next  = last_remove_reg;
        key_absent_next   = key_absent_reg;
        table_full_next   = table_full_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        if (cmd.commit)
        begin
            out_valid_next    = 1'b1;
            first_insert_next = 1'b0;
            last_remove_next  = 1'b0;
            key_absent_next   = 1'b0;
            table_full_next   = 1'b0;
            if (is_inc)
            begin
                if (found_reg)
                begin
                    ram_we    = 1'b1;
                    new_count = inc_count;
                end
                else if (free_found_reg)
                begin
                    ram_we                   = 1'b1;
                    new_count                = COUNT_W'(1);
                    valid_next[free_idx_reg] = 1'b1;
                    first_insert_next        = 1'b1;
                end
                else
                begin
                    table_full_next = 1'b1;
                end
            end
            else
            begin
                if (!found_reg)
                begin
                    key_absent_next = 1'b1;
                end
                else if (dec_frees)
                begin
                    valid_next[hit_idx_reg] = 1'b0;
                    last_remove_next        = 1'b1;
                end
                else
                begin
                    ram_we    = 1'b1;
                    new_count = sub_count;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg   <= '0;
            cmp_vld_reg    <= 1'b0;
            valid_reg      <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            scan_cnt_reg   <= scan_cnt_next;
            cmp_vld_reg    <= rd_en;
            valid_reg      <= valid_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            req_type_reg   <= req_type;
            req_key_reg    <= entry_key;
            req_amount_reg <= dec_amount;
        end
        cmp_idx_reg      <= scan_cnt_reg[IDX_W-1:0];
        hit_idx_reg      <= hit_idx_next;
        hit_count_reg    <= hit_count_next;
        free_idx_reg     <= free_idx_next;
        first_insert_reg <= first_insert_next;
        last_remove_reg  <= last_remove_next;
        key_absent_reg   <= key_absent_next;
        table_full_reg   <= table_full_next;
    end

    assign out_valid    = out_valid_reg;
    assign first_insert = first_insert_reg;
    assign last_remove  = last_remove_reg;
    assign key_absent   = key_absent_reg;
    assign table_full   = table_full_reg;

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before it was taken");

    a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot0({first_insert_reg, last_remove_reg,
                                    key_absent_reg, table_full_reg}))
        else $error("more than one result flag set");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed result not presented");

    a_no_read_on_update: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !rd_en)
        else $error("slot write during scan");

endmodule

`default_nettype wire

>>> rtl/lookup_reference_count_table.sv
`default_nettype none

// channel   handshake              fields
// input     in_valid / in_ready    req_type, entry_key, dec_amount
// output    out_valid / out_ready  first_insert, last_remove, key_absent, table_full
//
// one word at a time: accept, a scan of TABLE_ENTRIES slots, then an update
// the scan is set by the slot
// memory's single read port, read one slot per cycle during the scan
// rst_n clears the slot valid bits at once, so no clearing pass is needed
// a new word is taken while the previous result waits; the update cycle
// stalls until the output register is free

module lookup_reference_count_table (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          req_type,
    input  wire logic [lrct_pkg::KEY_W-1:0]    entry_key,
    input  wire logic [lrct_pkg::COUNT_W-1:0]  dec_amount,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               first_insert,
    output logic                               last_remove,
    output logic                               key_absent,
    output logic                               table_full
);

    import lrct_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    lrct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    lrct_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .req_type     (req_type),
        .entry_key    (entry_key),
        .dec_amount   (dec_amount),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .first_insert (first_insert),
        .last_remove  (last_remove),
        .key_absent   (key_absent),
        .table_full   (table_full)
    );

endmodule

`default_nettype wire
